FILE: hw/rtl/rc4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and codes for the 128-entry RC4-style stream cipher unit:
// controller states, word kind codes and keystream source selection.
// ----------------------------------------------------------------------------
package rc4_pkg;

  // Kind of an input word, carried on tuser.
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  // Controller states. GEN_* run one generator step, KS_* one key schedule step.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN_J,
    ST_GEN_SWAP,
    ST_GEN_OUT,
    ST_KS_READ,
    ST_KS_J,
    ST_KS_WR_N,
    ST_KS_WR_J
  } rc4_state_t;

  // Where the keystream value comes from when the read overlaps the swap.
  typedef enum logic [1:0] {
    KS_FROM_MEM,
    KS_FROM_SI,
    KS_FROM_SJ
  } ks_src_t;

endpackage : rc4_pkg
`default_nettype wire

FILE: hw/rtl/rc4_128_stream_cipher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_128_stream_cipher_unit
// RC4-style stream cipher over a permutation table held in a synchronous
// memory. Key words are collected, the final key word runs the key schedule,
// and every data word is XORed with one keystream value.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  --------  ---------  ----------------------------------------------------
//  s_axis    in         tuser = mode, tdata = byte_value, tlast = last_key
//  m_axis    out        tdata = data_out (one word per data input word)
//
// A data word takes the accept in IDLE plus three steps, set by the
// chain of dependent reads and two writes on the single table memory port.
// A key word is accepted in IDLE; the final key word adds a key schedule of
// four steps per table entry with tready low.
// Reset returns the table to identity at once through per-entry valid bits.
// The result register frees the input side: a new word is accepted while a
// result waits; a following result holds in its last step until taken.
module rc4_128_stream_cipher_unit #(
  parameter int TABLE_SIZE = 128,
  parameter int MAX_KEY    = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Input words.
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  wire logic [0:0] s_axis_tuser,   // [0] mode
  input  wire logic       s_axis_tlast,   // last_key
  // Result words.
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [7:0] data_out
);
  import rc4_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int KW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int CW = $clog2(MAX_KEY + 1);
  localparam logic [IW:0]   TS_W      = (IW + 1)'(TABLE_SIZE);
  localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] MAX_KEY_W = CW'(MAX_KEY);

  // Key byte reduced modulo the table size, built at elaboration.
  typedef logic [IW-1:0] kmod_tbl_t [256];

  function automatic kmod_tbl_t build_kmod();
    kmod_tbl_t tbl;
    for (int n = 0; n < 256; n++) begin
      tbl[n] = IW'(n % TABLE_SIZE);
    end
    return tbl;
  endfunction

  localparam kmod_tbl_t KEY_MOD = build_kmod();

  // Sum of two table values modulo the table size.
  function automatic logic [IW-1:0] add_mod(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= TS_W) begin
      s = s - TS_W;
    end
    return s[IW-1:0];
  endfunction

  rc4_state_t state, state_next;

  // Control and payload registers.
  logic [IW-1:0] gen_i;
  logic [IW-1:0] gen_j;
  logic [CW-1:0] key_count;
  logic [CW-1:0] key_len;
  logic [IW-1:0] sched_n;
  logic [KW-1:0] sched_k;
  logic [IW-1:0] sched_j;
  logic [IW-1:0] held_si;
  logic [IW-1:0] held_sj;
  logic [7:0]    data_byte;
  ks_src_t       ks_src;
  logic          out_valid;
  logic [7:0]    out_data;

  // Table memory with per-entry valid bits; an invalid entry reads as its index.
  logic [IW-1:0]         perm_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] perm_vld;
  logic [IW-1:0]         perm_rd_data;
  logic                  perm_rd_vld;
  logic [IW-1:0]         perm_rd_addr_q;

  // Key store memory.
  logic [7:0] key_mem [MAX_KEY];
  logic [7:0] key_rd_data;

  // Memory controls from the output decode.
  logic          perm_rd_en;
  logic [IW-1:0] perm_rd_addr;
  logic          perm_wr_en;
  logic [IW-1:0] perm_wr_addr;
  logic [IW-1:0] perm_wr_data;
  logic          perm_clr;
  logic          key_wr_en;
  logic          key_rd_en;

  // Datapath values.
  logic          in_acc;
  logic          in_is_data;
  logic          out_free;
  logic [IW-1:0] perm_val;
  logic [IW-1:0] gen_i_inc;
  logic [IW-1:0] gen_j_new;
  logic [IW-1:0] ks_addr;
  logic [IW-1:0] sched_j_new;
  logic [IW-1:0] ks_value;
  logic [CW-1:0] key_count_next;
  logic [CW-1:0] sched_k_inc;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_is_data    = (s_axis_tuser[0] == MODE_DATA);
  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Table value from the last read.
  assign perm_val    = perm_rd_vld ? perm_rd_data : perm_rd_addr_q;
  assign gen_i_inc   = add_mod(gen_i, IW'(1));
  assign gen_j_new   = add_mod(perm_val, gen_j);
  assign ks_addr     = add_mod(held_si, perm_val);
  assign sched_j_new = add_mod(add_mod(KEY_MOD[key_rd_data], perm_val), sched_j);
  assign sched_k_inc = CW'(sched_k) + CW'(1);
  assign key_count_next = (key_count < MAX_KEY_W) ? key_count + CW'(1) : key_count;

  // Keystream value, forwarded where the read hit a swapped entry.
  always_comb begin
    unique case (ks_src)
      KS_FROM_SI: ks_value = held_si;
      KS_FROM_SJ: ks_value = held_sj;
      default:    ks_value = perm_val;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_is_data) begin
            state_next = ST_GEN_J;
          end else if (s_axis_tlast) begin
            state_next = ST_KS_READ;
          end
        end
      end
      ST_GEN_J:    state_next = ST_GEN_SWAP;
      ST_GEN_SWAP: state_next = ST_GEN_OUT;
      ST_GEN_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_KS_READ:  state_next = ST_KS_J;
      ST_KS_J:     state_next = ST_KS_WR_N;
      ST_KS_WR_N:  state_next = ST_KS_WR_J;
      ST_KS_WR_J: begin
        state_next = (sched_n == LAST_IDX) ? ST_IDLE : ST_KS_READ;
      end
    endcase
  end

  // Memory access decode.
  always_comb begin
    perm_rd_en   = 1'b0;
    perm_rd_addr = '0;
    perm_wr_en   = 1'b0;
    perm_wr_addr = '0;
    perm_wr_data = '0;
    perm_clr     = 1'b0;
    key_wr_en    = 1'b0;
    key_rd_en    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && in_is_data) begin
          perm_rd_en   = 1'b1;
          perm_rd_addr = gen_i_inc;
        end
        if (in_acc && !in_is_data) begin
          key_wr_en = (key_count < MAX_KEY_W);
          perm_clr  = s_axis_tlast;
        end
      end
      ST_GEN_J: begin
        perm_rd_en   = 1'b1;
        perm_rd_addr = gen_j_new;
      end
      ST_GEN_SWAP: begin
        perm_wr_en   = 1'b1;
        perm_wr_addr = gen_i;
        perm_wr_data = perm_val;
        perm_rd_en   = 1'b1;
        perm_rd_addr = ks_addr;
      end
      ST_GEN_OUT: begin
        perm_wr_en   = 1'b1;
        perm_wr_addr = gen_j;
        perm_wr_data = held_si;
      end
      ST_KS_READ: begin
        perm_rd_en   = 1'b1;
        perm_rd_addr = sched_n;
        key_rd_en    = 1'b1;
      end
      ST_KS_J: begin
        perm_rd_en   = 1'b1;
        perm_rd_addr = sched_j_new;
      end
      ST_KS_WR_N: begin
        perm_wr_en   = 1'b1;
        perm_wr_addr = sched_n;
        perm_wr_data = perm_val;
      end
      ST_KS_WR_J: begin
        perm_wr_en   = 1'b1;
        perm_wr_addr = sched_j;
        perm_wr_data = held_si;
      end
    endcase
  end

  // Table memory array and registered read port.
  always_ff @(posedge clk) begin
    if (perm_wr_en) begin
      perm_mem[perm_wr_addr] <= perm_wr_data;
    end
    if (perm_rd_en) begin
      perm_rd_data   <= perm_mem[perm_rd_addr];
      perm_rd_addr_q <= perm_rd_addr;
    end
  end

  // Valid bits: cleared by reset and at the start of a key schedule.
  always_ff @(posedge clk) begin
    if (rst) begin
      perm_vld    <= '0;
      perm_rd_vld <= 1'b0;
    end else begin
      if (perm_clr) begin
        perm_vld <= '0;
      end else if (perm_wr_en) begin
        perm_vld[perm_wr_addr] <= 1'b1;
      end
      if (perm_rd_en) begin
        perm_rd_vld <= perm_vld[perm_rd_addr];
      end
    end
  end

  // Key store memory.
  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem[key_count[KW-1:0]] <= s_axis_tdata;
    end
    if (key_rd_en) begin
      key_rd_data <= key_mem[sched_k];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gen_i     <= '0;
      gen_j     <= '0;
      key_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Result register: loaded in the last generator step, freed when taken.
      if (state == ST_GEN_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && in_is_data) begin
            gen_i     <= gen_i_inc;
            data_byte <= s_axis_tdata;
          end
          if (in_acc && !in_is_data) begin
            if (s_axis_tlast) begin
              // Schedule clears the key count and both generator indices.
              key_count <= '0;
              key_len   <= key_count_next;
              gen_i     <= '0;
              gen_j     <= '0;
              sched_n   <= '0;
              sched_k   <= '0;
              sched_j   <= '0;
            end else begin
              key_count <= key_count_next;
            end
          end
        end
        ST_GEN_J: begin
          held_si <= perm_val;
          gen_j   <= gen_j_new;
        end
        ST_GEN_SWAP: begin
          held_sj <= perm_val;
          // Keystream read may land on an entry just swapped.
          if (ks_addr == gen_j) begin
            ks_src <= KS_FROM_SI;
          end else if (ks_addr == gen_i) begin
            ks_src <= KS_FROM_SJ;
          end else begin
            ks_src <= KS_FROM_MEM;
          end
        end
        ST_GEN_OUT: begin
          if (out_free) begin
            out_data <= data_byte ^ 8'(ks_value);
          end
        end
        ST_KS_READ: begin
        end
        ST_KS_J: begin
          held_si <= perm_val;
          sched_j <= sched_j_new;
        end
        ST_KS_WR_N: begin
        end
        ST_KS_WR_J: begin
          sched_n <= sched_n + IW'(1);
          sched_k <= (sched_k_inc == key_len) ? '0 : sched_k_inc[KW-1:0];
        end
      endcase
    end
  end

endmodule : rc4_128_stream_cipher_unit
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 128-entry RC4-style stream cipher unit. Key and
// data words go in on the input stream and every returned byte is checked
// against a cycle-free model of the permutation table, the key store and the
// generator indices that the bench keeps itself.
// ----------------------------------------------------------------------------
module tb_top;
  import rc4_pkg::*;

  localparam int PERM_SIZE   = 128;
  localparam int KEY_SLOTS   = 16;
  localparam int RANDOM_WORDS = 1050;
  localparam int QUIET_WORDS = 120;
  // Longest busy stretch with no result: one full key schedule.
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    logic       mode;
    logic [7:0] value;
    logic       last;
    bit         typed;
    logic [7:0] want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] byte_value
  logic [0:0] s_axis_tuser;   // [0] mode
  logic       s_axis_tlast;   // last_key
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;   // [7:0] data_out

  // Local copy of the cipher state.
  logic [6:0] perm[PERM_SIZE];
  logic [7:0] key_bytes[KEY_SLOTS];
  int         key_len;
  logic [6:0] idx_i;
  logic [6:0] idx_j;

  logic [7:0] expected_bytes[$];
  stim_row_t  directed_rows[25];
  bit         bursts_on = 1'b1;
  int         error_count = 0;
  int         bytes_checked = 0;
  int         data_words = 0;
  int         key_words = 0;
  int         schedules = 0;
  int         dropped_keys = 0;
  int         stall_left = 0;

  rc4_128_stream_cipher_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Exchange two table entries; an entry swapped with itself keeps its value.
  task automatic swap_perm(input logic [6:0] a, input logic [6:0] b);
    logic [6:0] tmp;
    tmp     = perm[a];
    perm[a] = perm[b];
    perm[b] = tmp;
  endtask

  task automatic clear_cipher();
    for (int n = 0; n < PERM_SIZE; n++) perm[n] = 7'(n);
    for (int n = 0; n < KEY_SLOTS; n++) key_bytes[n] = 8'h00;
    key_len = 0;
    idx_i   = '0;
    idx_j   = '0;
  endtask

  // Rebuild the table from the collected key and restart the generator.
  task automatic run_key_schedule();
    int         len;
    int         k;
    logic [6:0] j;
    len = (key_len == 0) ? 1 : key_len;
    if (len > KEY_SLOTS) len = KEY_SLOTS;
    for (int n = 0; n < PERM_SIZE; n++) perm[n] = 7'(n);
    j = '0;
    k = 0;
    for (int n = 0; n < PERM_SIZE; n++) begin
      j = 7'(int'(key_bytes[k]) + int'(perm[n]) + int'(j));
      swap_perm(7'(n), j);
      k = (k + 1) % len;
    end
    idx_i   = '0;
    idx_j   = '0;
    key_len = 0;
    schedules++;
  endtask

  // Apply one accepted word; a data word yields its encrypted byte.
  task automatic cipher_predict(input logic mode, input logic [7:0] value,
                                input logic last, output bit produced,
                                output logic [7:0] cipher_byte);
    logic [6:0] t;
    produced    = 1'b0;
    cipher_byte = '0;
    if (mode == MODE_KEY) begin
      key_words++;
      if (key_len < KEY_SLOTS) begin
        key_bytes[key_len] = value;
        key_len++;
      end else begin
        dropped_keys++;
      end
      if (last) run_key_schedule();
    end else begin
      data_words++;
      idx_i = idx_i + 7'd1;
      idx_j = idx_j + perm[idx_i];
      swap_perm(idx_i, idx_j);
      t           = perm[idx_i] + perm[idx_j];
      cipher_byte = value ^ {1'b0, perm[t]};
      produced    = 1'b1;
    end
  endtask

  // Offer one word, wait for the handshake, then record what it should produce.
  task automatic send_word(input logic mode, input logic [7:0] value,
                           input logic last, input bit typed,
                           input logic [7:0] want);
    int         gap;
    bit         produced;
    logic [7:0] cipher_byte;
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    cipher_predict(mode, value, last, produced, cipher_byte);
    if (produced) expected_bytes.push_back(typed ? want : cipher_byte);
  endtask

  task automatic wait_results_drained();
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall bursts on tready.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each returned word with the oldest expected byte.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected word data_out=%02h", m_axis_tdata));
      end else begin
        if (m_axis_tdata !== expected_bytes[0]) begin
          report_mismatch($sformatf("data_out=%02h, expected %02h",
                                    m_axis_tdata, expected_bytes[0]));
        end
        void'(expected_bytes.pop_front());
        bytes_checked++;
      end
    end
  end

  // Hard stop in case the unit hangs.
  initial begin
    #5_000_000;
    $display("Timeout: %0d bytes still expected", expected_bytes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int         sent;
    int         pick;
    int         klen;
    logic [7:0] kval;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    clear_cipher();

    // Identity table after reset gives keystream 2 then 5; an all-zero
    // single-byte key; an all-ones key; a 17-byte key whose tail is dropped.
    directed_rows = '{
      '{MODE_DATA, 8'h00, 1'b0, 1'b1, 8'h02},
      '{MODE_DATA, 8'hFF, 1'b1, 1'b1, 8'hFA},
      '{MODE_KEY,  8'h00, 1'b1, 1'b0, 8'h00},
      '{MODE_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'hFF, 1'b1, 1'b0, 8'h00},
      '{MODE_DATA, 8'hFF, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'h80, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'h7F, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'h01, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'hFE, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'h55, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'hAA, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'h00, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'hFF, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'h3C, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'hC3, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'h10, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'hEF, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'h42, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'hBD, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'h99, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'h66, 1'b0, 1'b0, 8'h00},
      '{MODE_KEY,  8'hA5, 1'b1, 1'b0, 8'h00},
      '{MODE_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
      '{MODE_DATA, 8'hFF, 1'b1, 1'b0, 8'h00}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].mode, directed_rows[r].value, directed_rows[r].last,
                directed_rows[r].typed, directed_rows[r].want);
    end

    // Hold off until every directed result has come back.
    s_axis_tvalid <= 1'b0;
    wait_results_drained();

    // Random part: mostly data words, with full keys, overlong keys and
    // stray key words that leave a key half collected.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent >= RANDOM_WORDS - QUIET_WORDS) bursts_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        klen = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 24)
                                           : $urandom_range(1, 16);
        for (int k = 0; k < klen; k++) begin
          kval = 8'($urandom_range(0, 255));
          send_word(MODE_KEY, kval, (k == klen - 1), 1'b0, 8'h00);
        end
        sent += klen;
      end else if (pick < 10) begin
        send_word(MODE_KEY, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 8'h00);
        sent++;
      end else begin
        send_word(MODE_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'b0, 8'h00);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let the last results and any running key schedule finish.
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d data words and %0d key words (%0d past the key store),",
             data_words, key_words, dropped_keys);
    $display("%0d key schedules, %0d output bytes compared.", schedules, bytes_checked);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_128_stream_cipher_unit.sv
sim/tb_top.sv
